// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of the moving-average block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/wma_pkg.sv =====
// Shared widths, constants and types for the windowed moving average.
// No dependencies; every other file but assert_macros.svh refers to it by scoped names.
package wma_pkg;

  localparam int SAMPLE_W       = 16;  // signed Q8.8 sample and average
  localparam int FILL_W         = 5;   // fill count, up to 16
  localparam int SUM_W          = 21;  // running sum of up to 16 samples
  localparam int WINDOW_DEFAULT = 10;

  // Status of the serial divider as seen by the sequencer.
  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] quotient;
  } div_status_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_START = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } seq_state_t;

endpackage

// ===== rtl/core/wma_if.sv =====
// Valid/ready channel interfaces for the moving-average block.
// Depends on wma_pkg for the field widths.
interface wma_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [wma_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface wma_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [wma_pkg::SAMPLE_W-1:0] average;
  logic        [wma_pkg::FILL_W-1:0]   fill_count;

  modport source (output valid, output average, output fill_count, input ready);
  modport sink   (input valid, input average, input fill_count, output ready);
endinterface

// ===== rtl/core/windowed_moving_average.sv =====
// Windowed moving average of signed Q8.8 samples over the last WINDOW samples
// (2 to 16), with a running sum and a fill count that saturates at WINDOW.
// Each result is the sum divided by the fill count, truncated toward zero.
// One sample is handled at a time: a sample is loaded into the running sum, the
// bit-serial divider runs, and the result moves into an output register, where it
// is held until taken; the next sample is accepted while it waits there, but a
// result still waiting there holds back the next one. Depends on wma_pkg, wma_if,
// wma_ring and wma_div.
module windowed_moving_average #(
  parameter int WINDOW = wma_pkg::WINDOW_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  wma_sample_if.sink   samples,
  wma_result_if.source averages
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int SUM_W  = wma_pkg::SUM_W;
  localparam int FILL_W = wma_pkg::FILL_W;

  wma_pkg::seq_state_t                 state;
  wma_pkg::seq_state_t                 state_next;
  logic signed [wma_pkg::SAMPLE_W-1:0] sample_reg;
  logic signed [wma_pkg::SAMPLE_W-1:0] oldest;
  logic signed [SUM_W-1:0]             running_sum;
  logic        [SLOT_W-1:0]            write_slot;
  logic        [FILL_W-1:0]            filled;
  logic                                full;
  logic                                take;
  logic                                out_free;
  logic                                out_valid;
  logic signed [wma_pkg::SAMPLE_W-1:0] average_reg;
  logic        [FILL_W-1:0]            fill_reg;
  wma_pkg::div_status_t                div_status;

  assign samples.ready = (state == wma_pkg::S_IDLE) && !rst;
  assign take          = samples.valid && samples.ready;
  assign full          = filled == FILL_W'(WINDOW);
  assign out_free      = !out_valid || averages.ready;

  wma_ring #(.WINDOW(WINDOW), .SLOT_W(SLOT_W)) u_ring (
    .clk     (clk),
    .en      (take),
    .slot    (write_slot),
    .wr_data (samples.sample),
    .rd_data (oldest)
  );

  wma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == wma_pkg::S_START),
    .dividend (running_sum),
    .divisor  (filled),
    .status   (div_status)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      wma_pkg::S_IDLE:  if (take) state_next = wma_pkg::S_LOAD;
      wma_pkg::S_LOAD:  state_next = wma_pkg::S_START;
      wma_pkg::S_START: state_next = wma_pkg::S_DIV;
      wma_pkg::S_DIV:   if (div_status.done) state_next = wma_pkg::S_OUT;
      wma_pkg::S_OUT:   if (out_free) state_next = wma_pkg::S_IDLE;
      default:          state_next = wma_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= wma_pkg::S_IDLE;
      running_sum <= '0;
      write_slot  <= '0;
      filled      <= '0;
    end else begin
      state <= state_next;
      if (state == wma_pkg::S_LOAD) begin
        // Slots not yet written count as zero until the ring has filled.
        running_sum <= running_sum
                       - (full ? SUM_W'(oldest) : SUM_W'(0))
                       + SUM_W'(sample_reg);
        write_slot  <= (write_slot == SLOT_W'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
        if (!full) begin
          filled <= filled + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sample_reg <= samples.sample;
    end
  end

  // Output register: hold the result until the sink takes the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == wma_pkg::S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (averages.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == wma_pkg::S_OUT && out_free) begin
      average_reg <= div_status.quotient;
      fill_reg    <= filled;
    end
  end

  assign averages.valid      = out_valid;
  assign averages.average    = average_reg;
  assign averages.fill_count = fill_reg;

endmodule

// ===== rtl/core/wma_ring.sv =====
// Sample ring memory: one write and one registered read per enabled cycle at one slot.
// Depends on wma_pkg for the sample width.
module wma_ring #(
  parameter int WINDOW = wma_pkg::WINDOW_DEFAULT,
  parameter int SLOT_W = $clog2(WINDOW)
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic        [SLOT_W-1:0]            slot,
  input  logic signed [wma_pkg::SAMPLE_W-1:0] wr_data,
  output logic signed [wma_pkg::SAMPLE_W-1:0] rd_data
);

  logic signed [wma_pkg::SAMPLE_W-1:0] mem [WINDOW];

  // Read returns the entry as it was before this write.
  always_ff @(posedge clk) begin
    if (en) begin
      rd_data   <= mem[slot];
      mem[slot] <= wr_data;
    end
  end

endmodule

// ===== rtl/core/wma_div.sv =====
// Restoring divider, one quotient bit per cycle: signed sum over unsigned count,
// truncated toward zero. Depends on wma_pkg for widths and the status struct.
module wma_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [wma_pkg::SUM_W-1:0]   dividend,
  input  logic        [wma_pkg::FILL_W-1:0]  divisor,
  output wma_pkg::div_status_t               status
);

  localparam int MAG_W = wma_pkg::SUM_W;
  localparam int CNT_W = $clog2(MAG_W + 1);
  localparam int REM_W = wma_pkg::FILL_W;

  logic                      busy;
  logic                      done;
  logic [CNT_W-1:0]          cnt;
  logic [REM_W-1:0]          rem;
  logic [MAG_W-1:0]          quo;
  logic [REM_W-1:0]          dvs;
  logic                      neg;
  logic [REM_W:0]            partial;
  logic [REM_W:0]            diff;
  logic                      fits;
  logic [wma_pkg::SAMPLE_W-1:0] q_low;

  assign partial = {rem, quo[MAG_W-1]};
  assign diff    = partial - {1'b0, dvs};
  assign fits    = partial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(MAG_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[MAG_W-1];
      quo <= dividend[MAG_W-1] ? MAG_W'(-dividend) : MAG_W'(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[REM_W-1:0];
        quo <= {quo[MAG_W-2:0], 1'b1};
      end else begin
        rem <= partial[REM_W-1:0];
        quo <= {quo[MAG_W-2:0], 1'b0};
      end
    end
  end

  // The mean of 16-bit samples always fits 16 bits; apply the sign last.
  assign q_low           = quo[wma_pkg::SAMPLE_W-1:0];
  assign status.done     = done;
  assign status.quotient = neg ? $signed(-q_low) : $signed(q_low);

endmodule

// ===== rtl/core/wma_checker.sv =====
// Port-level checks for windowed_moving_average, attached by bind.
// Depends on assert_macros.svh and wma_pkg.
`include "assert_macros.svh"

module wma_checker #(
  parameter int WINDOW = wma_pkg::WINDOW_DEFAULT
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                samples_valid,
  input logic                                samples_ready,
  input logic                                averages_valid,
  input logic                                averages_ready,
  input logic signed [wma_pkg::SAMPLE_W-1:0] average,
  input logic        [wma_pkg::FILL_W-1:0]   fill_count
);

  // One sample in flight: the port closes right after a transfer.
  `ASSERT_NEXT(a_one_in_flight, samples_valid && samples_ready, !samples_ready, "ready after transfer")

  // Fill count on a result lies within one to WINDOW.
  `ASSERT_SAME(a_fill_range, averages_valid, fill_count != 0 && fill_count <= wma_pkg::FILL_W'(WINDOW), "fill count out of range")

  // A stalled result holds its payload.
  `ASSERT_NEXT(a_out_hold, averages_valid && !averages_ready, averages_valid && $stable(average) && $stable(fill_count), "stalled result changed")

endmodule

bind windowed_moving_average wma_checker #(.WINDOW(WINDOW)) u_wma_checker (
  .clk            (clk),
  .rst            (rst),
  .samples_valid  (samples.valid),
  .samples_ready  (samples.ready),
  .averages_valid (averages.valid),
  .averages_ready (averages.ready),
  .average        (averages.average),
  .fill_count     (averages.fill_count)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for windowed_moving_average: directed and random samples on
// a valid/ready channel, with averages predicted by a running-sum model of the sample window.
// Depends on wma_pkg, wma_if and the block's RTL.
module tb_top;

  localparam int SAMPLE_W = wma_pkg::SAMPLE_W;
  localparam int FILL_W = wma_pkg::FILL_W;
  localparam int SUM_W = wma_pkg::SUM_W;
  localparam int WINDOW = wma_pkg::WINDOW_DEFAULT;
  localparam int RANDOM_ITEMS = 930;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int QUIET_FROM = 6000;
  localparam int QUIET_TO = 9000;

  typedef struct {
    logic signed [SAMPLE_W-1:0] average;
    logic        [FILL_W-1:0]   fill_count;
  } mean_t;

  logic clk;
  logic rst;

  wma_sample_if sample_ch ();
  wma_result_if result_ch ();

  windowed_moving_average #(.WINDOW(WINDOW)) u_top (
    .clk      (clk),
    .rst      (rst),
    .samples  (sample_ch),
    .averages (result_ch)
  );

  // Window model: ring, running sum, next slot and saturating fill count.
  logic signed [SAMPLE_W-1:0] window_ring [WINDOW];
  logic signed [SUM_W-1:0]    window_sum;
  logic        [3:0]          next_slot;
  logic        [FILL_W-1:0]   fill_seen;

  logic signed [SAMPLE_W-1:0] pending_samples [$];
  mean_t                      expected_means [$];

  int  cycle_count;
  int  samples_sent;
  int  means_checked;
  int  failures;
  int  max_fill_seen;
  int  input_stalls;
  logic hold_off;

  function automatic mean_t advance_window(logic signed [SAMPLE_W-1:0] s);
    mean_t r;
    int    quotient;
    window_sum = window_sum - window_ring[next_slot] + s;
    window_ring[next_slot] = s;
    if (next_slot == WINDOW - 1) begin
      next_slot = '0;
    end else begin
      next_slot = next_slot + 1'b1;
    end
    if (fill_seen < WINDOW) begin
      fill_seen = fill_seen + 1'b1;
    end
    // SystemVerilog integer division truncates toward zero
    quotient = int'(window_sum) / int'(fill_seen);
    r.average = quotient[SAMPLE_W-1:0];
    r.fill_count = fill_seen;
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    int pick;
    logic [31:0] raw;
    pick = $urandom_range(99);
    raw = $urandom;
    if (pick < 60) begin
      return raw[SAMPLE_W-1:0];
    end else if (pick < 80) begin
      return raw[0] ? 16'sh7FFF : 16'sh8000;
    end else begin
      return SAMPLE_W'($signed($urandom_range(8)) - 4);
    end
  endfunction

  function automatic logic quiet_now();
    return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
  endfunction

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    rst = 1'b1;
    sample_ch.valid = 1'b0;
    sample_ch.sample = '0;
    result_ch.ready = 1'b0;
    hold_off = 1'b0;
    for (int i = 0; i < WINDOW; i++) begin
      window_ring[i] = '0;
    end
    window_sum = '0;
    next_slot = '0;
    fill_seen = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
    end
  end

  // Sample driver: predict on each transfer, then offer the next pending item.
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        expected_means.push_back(advance_window(sample_ch.sample));
        samples_sent <= samples_sent + 1;
      end
      if (sample_ch.valid && !sample_ch.ready) begin
        input_stalls <= input_stalls + 1;
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (pending_samples.size() != 0 && (quiet_now() || $urandom_range(99) >= 33)) begin
          sample_ch.valid <= 1'b1;
          sample_ch.sample <= pending_samples.pop_front();
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk) begin
    mean_t want;
    int    errs;
    errs = 0;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_means.size() == 0) begin
          $display("%0t: unexpected result: average %0d fill_count %0d", $time,
                   result_ch.average, result_ch.fill_count);
          errs = errs + 1;
        end else begin
          want = expected_means.pop_front();
          if (result_ch.average !== want.average) begin
            $display("%0t: average mismatch: expected %0d, actual %0d", $time,
                     want.average, result_ch.average);
            errs = errs + 1;
          end
          if (result_ch.fill_count !== want.fill_count) begin
            $display("%0t: fill_count mismatch: expected %0d, actual %0d", $time,
                     want.fill_count, result_ch.fill_count);
            errs = errs + 1;
          end
          if (want.fill_count > max_fill_seen) begin
            max_fill_seen <= want.fill_count;
          end
          means_checked <= means_checked + 1;
        end
        failures <= failures + errs;
      end
      result_ch.ready <= !hold_off && (quiet_now() || $urandom_range(99) >= 33);
    end
  end

  // Hold off the receiver long enough that the block backs up its input.
  initial begin
    @(negedge rst);
    while (means_checked < 40) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    samples_sent = 0;
    means_checked = 0;
    failures = 0;
    max_fill_seen = 0;
    input_stalls = 0;

    // Partial fill at the top extreme, then drive the window to the bottom
    // extreme so the wrap subtracts stored maxima.
    repeat (3) pending_samples.push_back(16'sh7FFF);
    repeat (10) pending_samples.push_back(16'sh8000);
    // Negative sums that do not divide evenly: quotient truncates toward zero.
    pending_samples.push_back(16'sh7FFF);
    pending_samples.push_back(-16'sd1);
    pending_samples.push_back(16'sd1);
    pending_samples.push_back(-16'sd3);
    pending_samples.push_back(16'sd0);
    repeat (3) pending_samples.push_back(16'sh7FFF);
    pending_samples.push_back(16'sh5555);
    pending_samples.push_back(16'shAAAA);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pending_samples.push_back(random_sample());
    end

    @(negedge rst);
    while (pending_samples.size() != 0 || sample_ch.valid) @(posedge clk);
    while (expected_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples, checked %0d averages, fill count reached %0d of %0d.",
             samples_sent, means_checked, max_fill_seen, WINDOW);
    $display("Input waited %0d cycles in all, including a long receiver hold-off.",
             input_stalls);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout at %0t: %0d averages still expected", $time, expected_means.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
